// ===== sv/askf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// askf_pkg
// Shared types and constants of the scalar Kalman filter core.
// ----------------------------------------------------------------------------
package askf_pkg;

	localparam int unsigned DATA_W    = 32;
	localparam int unsigned RATE_W    = 17;
	localparam int unsigned NUM_REGS  = 2;
	localparam int unsigned IDX_W     = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int unsigned DIV_STEPS = 17;
	localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

	localparam logic [IDX_W-1:0]  REG_NOISE = IDX_W'(0);
	localparam logic [IDX_W-1:0]  REG_RATE  = IDX_W'(1);

	localparam logic [DATA_W-1:0] NOISE_RESET = 32'd328;
	localparam logic [RATE_W-1:0] RATE_RESET  = 17'd58982;
	localparam logic [RATE_W-1:0] ONE_Q16     = 17'd65536;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL_D,
		ST_MUL_E1,
		ST_MUL_E2,
		ST_SUM
	} state_t;

	typedef enum logic [1:0] {
		MUL_DELTA,
		MUL_E1,
		MUL_E2
	} mul_sel_t;

	typedef struct packed {
		logic     start;
		logic     div_step;
		logic     div_last;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     take_delta;
		logic     take_e1;
		logic     commit;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} sts_t;

endpackage
`default_nettype wire

// ===== sv/adaptive_scalar_kalman_filter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adaptive_scalar_kalman_filter_core
// Scalar Kalman smoother for Q16.16 samples.
//
// A word on s_* carries one signed Q16.16 sample; each sample yields one
// word on m_* with the new signed Q16.16 estimate. The cfg port writes the
// measurement noise (index 0, unsigned Q16.16) and the change rate (index 1,
// unsigned Q1.16); write only while no sample is in flight.
// A noise write reloads the error from the noise and clears the estimate.
// The accepting edge also loads the operands. The restoring gain divider
// then forms the 17-bit quotient, one quotient bit per cycle; the shared
// 18x34 multiplier forms the three products; then the result is committed.
// The sequencer runs one sample at a time and passes through its idle
// state to take the next word; no new word is taken before the commit.
// s_tready is high only while the sequencer is idle. A finished result
// sits in the output register while the next sample is taken; if that
// result is still unread when the next one is ready, the core holds it
// until m_tready frees the register.
// Reset restores noise 328, change rate 58982, estimate 0, error = noise.
// ----------------------------------------------------------------------------
module adaptive_scalar_kalman_filter_core
	import askf_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_we,
	input  wire  [IDX_W-1:0]  cfg_index,
	input  wire  [DATA_W-1:0] cfg_data,
	input  wire               s_tvalid,
	output logic              s_tready,
	input  wire  [DATA_W-1:0] s_tdata,  // [31:0] sample
	output logic              m_tvalid,
	input  wire               m_tready,
	output logic [DATA_W-1:0] m_tdata   // [31:0] estimate
);

	cmd_t cmd;
	sts_t sts;

	askf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	askf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
`default_nettype wire

// ===== sv/askf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// askf_ctrl
// Sequencer: accept a word, run the divide steps, issue the three products
// on the shared multiplier, then commit the new state and result.
// ----------------------------------------------------------------------------
module askf_ctrl
	import askf_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.start) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.mul_sel = MUL_DELTA;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					cmd.div_last = 1'b1;
					state_d      = ST_MUL_D;
				end
			end
			ST_MUL_D: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_DELTA;
				state_d     = ST_MUL_E1;
			end
			ST_MUL_E1: begin
				cmd.mul_en     = 1'b1;
				cmd.mul_sel    = MUL_E1;
				cmd.take_delta = 1'b1;
				state_d        = ST_MUL_E2;
			end
			ST_MUL_E2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_E2;
				cmd.take_e1 = 1'b1;
				state_d     = ST_SUM;
			end
			ST_SUM: begin
				if (!sts.out_busy) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_start_div: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_DIV && cnt_q == '0))
		else $error("accepted word did not start the divide");

	a_hold_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM && sts.out_busy) |=> (state_q == ST_SUM))
		else $error("result committed while output register full");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q < CNT_W'(DIV_STEPS)))
		else $error("divide step count overran");

endmodule
`default_nettype wire

// ===== sv/askf_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// askf_dp
// Datapath: configuration registers, filter state, restoring divider for
// the gain, shared multiplier, error update and output register.
// ----------------------------------------------------------------------------
module askf_dp
	import askf_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_we,
	input  wire  [IDX_W-1:0]  cfg_index,
	input  wire  [DATA_W-1:0] cfg_data,
	input  wire  [DATA_W-1:0] s_tdata,
	output logic              m_tvalid,
	input  wire               m_tready,
	output logic [DATA_W-1:0] m_tdata,
	input  cmd_t              cmd,
	output sts_t              sts
);

	logic [DATA_W-1:0] noise_q;
	logic [RATE_W-1:0] rate_q;
	logic [DATA_W-1:0] last_q;
	logic [DATA_W-1:0] err_q;

	logic [DATA_W-1:0] sample_q;
	logic [32:0]       den_q;
	logic [32:0]       rem_q;
	logic              bit_q;
	logic [16:0]       quo_q;
	logic [16:0]       gain_q;
	logic signed [51:0] prod_q;
	logic [DATA_W-1:0] nv_q;
	logic [32:0]       amove_q;
	logic [32:0]       e1_q;

	logic [33:0]       rem_sh;
	logic              rem_ge;
	logic [33:0]       rem_nxt;
	logic [16:0]       quo_nxt;

	logic signed [17:0] mul_a;
	logic signed [33:0] mul_b;
	logic signed [51:0] mul_p;
	logic signed [32:0] diff;

	logic signed [51:0] prod_sh;
	logic signed [32:0] delta;
	logic [32:0]        amove;
	logic [33:0]        e2;
	logic [34:0]        enew;
	logic [DATA_W-1:0]  err_sat;

	// restoring divide, one quotient bit per step
	always_comb begin
		rem_sh  = {rem_q, bit_q};
		rem_ge  = (rem_sh >= {1'b0, den_q});
		rem_nxt = rem_ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
		quo_nxt = {quo_q[15:0], rem_ge};
	end

	always_comb begin
		diff = $signed({sample_q[31], sample_q}) - $signed({last_q[31], last_q});
		case (cmd.mul_sel)
			MUL_DELTA: begin
				mul_a = $signed({1'b0, gain_q});
				mul_b = $signed({diff[32], diff});
			end
			MUL_E1: begin
				mul_a = $signed({1'b0, ONE_Q16 - gain_q});
				mul_b = $signed({2'b00, err_q});
			end
			MUL_E2: begin
				mul_a = $signed({1'b0, rate_q});
				mul_b = $signed({1'b0, amove_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	always_comb begin
		prod_sh = prod_q >>> 16;
		delta   = prod_sh[32:0];
		amove   = delta[32] ? (~delta + 33'd1) : delta;
		e2      = prod_q[49:16];
		enew    = {2'b00, e1_q} + {1'b0, e2};
		err_sat = (|enew[34:32]) ? '1 : enew[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_q  <= NOISE_RESET;
			rate_q   <= RATE_RESET;
			last_q   <= '0;
			err_q    <= NOISE_RESET;
			m_tvalid <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_NOISE: begin
						noise_q <= cfg_data;
						err_q   <= cfg_data;
						last_q  <= '0;
					end
					REG_RATE: begin
						rate_q <= cfg_data[RATE_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (cmd.commit) begin
				last_q   <= nv_q;
				err_q    <= err_sat;
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sample_q <= s_tdata;
			den_q    <= {1'b0, err_q} + {1'b0, noise_q};
			rem_q    <= {2'b00, err_q[31:1]};
			bit_q    <= err_q[0];
			quo_q    <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= rem_nxt[32:0];
			quo_q <= quo_nxt;
			bit_q <= 1'b0;
			if (cmd.div_last) begin
				gain_q <= (den_q == '0) ? '0 : quo_nxt;
			end
		end
		if (cmd.mul_en) begin
			prod_q <= mul_p;
		end
		if (cmd.take_delta) begin
			nv_q    <= last_q + delta[31:0];
			amove_q <= amove;
		end
		if (cmd.take_e1) begin
			e1_q <= prod_q[48:16];
		end
		if (cmd.commit) begin
			m_tdata <= nv_q;
		end
	end

	assign sts.out_busy = m_tvalid && !m_tready;

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_en |-> (gain_q <= ONE_Q16))
		else $error("gain above one");

	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> (m_tvalid && m_tdata == last_q))
		else $error("result word differs from stored estimate");

	a_e1_sign: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_e1 |-> (prod_q[51:49] == 3'b000))
		else $error("error product out of range");

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the scalar Kalman smoother core.
//
// Streams signed Q16.16 samples into the core and predicts every estimate
// in the bench from its own copy of the filter state. Directed items cover
// field extremes, a zero denominator, change-rate writes that keep the
// state, and error saturation. Random items follow a drifting signal plus
// noise of random size, mixed with raw and extreme words. Four idling
// phases, periodic register rewrites, a long output hold-off and drain
// pauses are applied.
// ----------------------------------------------------------------------------
module testbench;
	import askf_pkg::*;

	localparam int     CYCLE_LIMIT = 1000000;
	localparam int     SETTLE      = 24;
	localparam int     HOLD_CYCLES = 400;
	localparam int     PHASE_ITEMS = 500;
	localparam int     REWRITE_GAP = 125;
	localparam int     PRINT_CAP   = 100;
	localparam longint ERR_MAX     = 64'h0000_0000_FFFF_FFFF;

	logic              clk;
	logic              arst_n    = 1'b0;
	logic              cfg_we    = 1'b0;
	logic [IDX_W-1:0]  cfg_index = '0;
	logic [DATA_W-1:0] cfg_data  = '0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata   = '0;  // [31:0] sample
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [DATA_W-1:0] m_tdata;         // [31:0] estimate

	logic [DATA_W-1:0] noise_reg = NOISE_RESET;
	logic [RATE_W-1:0] rate_reg  = RATE_RESET;
	logic [DATA_W-1:0] est_last  = '0;
	logic [DATA_W-1:0] err_est   = NOISE_RESET;
	logic [DATA_W-1:0] estimate_q[$];
	logic [DATA_W-1:0] want_estimate;

	longint sensor_truth  = 0;
	int     tx_idle_pct   = 0;
	int     rx_stall_pct  = 0;
	bit     hold_token    = 1'b0;
	bit     hold_seen     = 1'b0;
	int     hold_left     = 0;
	int     cycle_count   = 0;
	int     error_count   = 0;
	int     sent_count    = 0;
	int     checked_count = 0;
	int     cfg_count     = 0;

	adaptive_scalar_kalman_filter_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("simulation failed");
			$finish;
		end
	end

	task automatic report_error(input string msg);
		if (error_count < PRINT_CAP)
			$display("ERROR at %0t: %s", $time, msg);
		error_count++;
	endtask

	// advance the filter state by one sample, return the new estimate
	function automatic logic [DATA_W-1:0] kalman_step(input logic [DATA_W-1:0] sample);
		longint smp, prev, errv, den, gain, nv, mv, e_new;
		smp  = longint'($signed(sample));
		prev = longint'($signed(est_last));
		errv = longint'(err_est);
		den  = errv + longint'(noise_reg);
		gain = (den != 0) ? (errv <<< 16) / den : 0;
		nv   = prev + ((gain * (smp - prev)) >>> 16);
		mv   = (prev > nv) ? prev - nv : nv - prev;
		e_new = (((longint'(ONE_Q16) - gain) * errv) >>> 16)
			+ ((mv * longint'(rate_reg)) >>> 16);
		if (e_new > ERR_MAX)
			e_new = ERR_MAX;
		err_est  = e_new[DATA_W-1:0];
		est_last = nv[DATA_W-1:0];
		return est_last;
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (estimate_q.size() == 0) begin
				report_error($sformatf("estimate %h with none pending", m_tdata));
			end else begin
				want_estimate = estimate_q.pop_front();
				if (m_tdata !== want_estimate)
					report_error($sformatf("estimate %h, want %h", m_tdata, want_estimate));
				checked_count++;
			end
		end
		if (hold_token != hold_seen) begin
			hold_seen <= hold_token;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
		end
	end

	task automatic send_sample(input logic [DATA_W-1:0] smp);
		int gap;
		gap = 0;
		while (gap < 200 && $urandom_range(0, 99) < tx_idle_pct)
			gap++;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		estimate_q.push_back(kalman_step(smp));
		sent_count++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (estimate_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_NOISE) begin
			noise_reg = val;
			err_est   = val;
			est_last  = '0;
		end else begin
			rate_reg = val[RATE_W-1:0];
		end
		cfg_count++;
		@(posedge clk);
	endtask

	function automatic logic [DATA_W-1:0] pick_noise();
		case ($urandom_range(0, 9))
			0: return 32'd1;
			1: return 32'hFFFF_FFFF;
			2: return 32'd0;
			default: return $urandom >> $urandom_range(0, 31);
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_rate();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return 32'(ONE_Q16);
			2: return 32'h0001_FFFF;
			3: return 32'($urandom_range(0, 32'h0001_FFFF));
			default: return 32'($urandom_range(0, 65536));
		endcase
	endfunction

	// drifting signal plus noise of random size, with raw and extreme words mixed in
	function automatic logic [DATA_W-1:0] next_sample();
		longint amp, v;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			return $urandom;
		if (pick < 15) begin
			case ($urandom_range(0, 3))
				0: return 32'h7FFF_FFFF;
				1: return 32'h8000_0000;
				2: return 32'h0000_0000;
				default: return 32'hFFFF_FFFF;
			endcase
		end
		sensor_truth += (longint'($urandom_range(0, 2048)) - 1024) <<< $urandom_range(0, 16);
		if (sensor_truth > (longint'(1) <<< 30))
			sensor_truth = longint'(1) <<< 30;
		if (sensor_truth < -(longint'(1) <<< 30))
			sensor_truth = -(longint'(1) <<< 30);
		amp = longint'(1) <<< $urandom_range(0, 29);
		v = sensor_truth + longint'($urandom_range(0, 32'(2 * amp))) - amp;
		return v[DATA_W-1:0];
	endfunction

	task automatic test_reset_defaults();
		send_sample(32'h0000_0000);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h8000_0000);
		send_sample(32'hFFFF_FFFF);
		send_sample(32'h0000_0001);
		send_sample(32'h0001_0000);
	endtask

	task automatic test_zero_denominator();
		write_reg(REG_NOISE, 32'd0);
		send_sample(32'h1234_5678);
		send_sample(32'h8000_0000);
	endtask

	task automatic test_rate_write_keeps_state();
		write_reg(REG_NOISE, 32'd1);
		send_sample(32'h0040_0000);
		send_sample(32'hFFC0_0000);
		write_reg(REG_RATE, 32'd0);
		send_sample(32'h0100_0000);
		send_sample(32'h0000_8000);
		write_reg(REG_RATE, 32'(ONE_Q16));
		send_sample(32'hF000_0000);
	endtask

	task automatic test_saturation();
		write_reg(REG_NOISE, 32'hFFFF_FFFF);
		write_reg(REG_RATE, 32'h0001_FFFF);
		repeat (3) begin
			send_sample(32'h7FFF_FFFF);
			send_sample(32'h8000_0000);
		end
	endtask

	task automatic run_phase(input int tx_pct, input int rx_pct);
		tx_idle_pct = tx_pct;
		rx_stall_pct <= rx_pct;
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			if (i % REWRITE_GAP == 0) begin
				write_reg(REG_NOISE, pick_noise());
				write_reg(REG_RATE, pick_rate());
			end
			if (i == PHASE_ITEMS / 2)
				drain_results();
			send_sample(next_sample());
		end
	endtask

	task automatic test_random_phases();
		run_phase(0, 0);
		run_phase(86, 0);
		run_phase(0, 86);
		run_phase(20, 20);
	endtask

	task automatic test_backpressure();
		write_reg(REG_NOISE, 32'd328);
		tx_idle_pct = 0;
		rx_stall_pct <= 0;
		hold_token <= ~hold_token;
		repeat (20) send_sample(next_sample());
		drain_results();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_zero_denominator();
		test_rate_write_keeps_state();
		test_saturation();
		test_random_phases();
		test_backpressure();
		drain_results();
		$display("sent %0d samples, checked %0d estimates, %0d register writes",
			sent_count, checked_count, cfg_count);
		$display("idling: none, sender, receiver, both; plus one long output hold-off");
		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches", error_count);
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/askf_pkg.sv
sv/askf_ctrl.sv
sv/askf_dp.sv
sv/adaptive_scalar_kalman_filter_core.sv
verif/testbench.sv
